// ===== hdl/ole_pkg.sv =====
// Shared types, constants and helpers for the ordered list engine.
package ole_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 5;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// operation codes
	localparam logic [3:0] K_PUSH_FRONT = 4'd0;
	localparam logic [3:0] K_PUSH_BACK  = 4'd1;
	localparam logic [3:0] K_POP_FRONT  = 4'd2;
	localparam logic [3:0] K_POP_BACK   = 4'd3;
	localparam logic [3:0] K_FRONT      = 4'd4;
	localparam logic [3:0] K_BACK       = 4'd5;
	localparam logic [3:0] K_INSERT     = 4'd6;
	localparam logic [3:0] K_REMOVE     = 4'd7;
	localparam logic [3:0] K_FIND       = 4'd8;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_IDX   = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic [3:0]               kind;
		logic [POS_W-1:0]         position_in;
		logic signed [DATA_W-1:0] value_in;
	} in_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] value_out;
		logic [POS_W-1:0]         position_out;
		logic [POS_W-1:0]         count;
	} out_word_t;

	// finished operation, one cycle wide
	typedef struct packed {
		logic              valid;
		logic [1:0]        status;
		logic [DATA_W-1:0] value;
		logic [POS_W-1:0]  pos;
		logic [CNT_W-1:0]  cnt;
	} fin_t;

	// one cycle of RAM traffic
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

	// keep the low bits of a position or count for the result word
	function automatic logic [POS_W-1:0] to_pos5(input logic [WIDE_W-1:0] v);
		logic [WIDE_W+POS_W-1:0] tmp;
		tmp = {{POS_W{1'b0}}, v};
		return tmp[POS_W-1:0];
	endfunction

endpackage

// ===== hdl/ole_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module ole_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ole_ctrl.sv =====
// Sequencer: decodes a command and walks the entry RAM to shift, read or search.
module ole_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  ole_pkg::in_word_t              cmd,
	output logic                           busy,
	output ole_pkg::fin_t                  fin,
	output ole_pkg::ram_req_t              ram,
	input  logic [ole_pkg::DATA_W-1:0]     rdata
);
	import ole_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_PUT} state_t;
	typedef enum logic [1:0] {M_UP, M_DOWN, M_READ, M_FIND} mode_t;

	state_t            state_q;
	mode_t             mode_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              iss_q;
	logic              rd_vld_s1;
	logic [IDX_W-1:0]  rd_addr_s1;
	logic [IDX_W-1:0]  rd_addr_q;
	logic [IDX_W-1:0]  tgt_q;
	logic [IDX_W-1:0]  stop_q;
	logic [DATA_W-1:0] val_q;
	logic [DATA_W-1:0] res_val_q;
	logic [POS_W-1:0]  res_pos_q;

	// decode
	logic              acc;
	logic              imm;
	logic [1:0]        imm_status;
	logic [DATA_W-1:0] imm_val;
	logic [POS_W-1:0]  imm_pos;
	logic              go_walk;
	logic              go_put;
	mode_t             nx_mode;
	logic [IDX_W-1:0]  nx_tgt;
	logic [IDX_W-1:0]  nx_stop;
	logic [IDX_W-1:0]  nx_addr;
	logic [POS_W-1:0]  nx_pos;

	// walk
	logic match;
	logic drained;
	logic walk_end;
	logic issue;

	assign acc  = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);

	always_comb begin
		logic [WIDE_W-1:0] c_w;
		logic [WIDE_W-1:0] p_w;
		logic [CNT_W-1:0]  c_m1;
		logic [CNT_W-1:0]  tgt_c;
		logic [IDX_W-1:0]  p;
		logic              full;
		logic              empty;
		c_w        = WIDE_W'(cnt_q);
		p_w        = WIDE_W'(cmd.position_in);
		c_m1       = cnt_q - 1'b1;
		full       = (cnt_q >= CAP_CNT);
		empty      = (cnt_q == '0);
		tgt_c      = '0;
		p          = '0;
		imm        = 1'b0;
		imm_status = ST_OK;
		imm_val    = '0;
		imm_pos    = '0;
		go_walk    = 1'b0;
		go_put     = 1'b0;
		nx_mode    = M_UP;
		nx_tgt     = '0;
		nx_stop    = '0;
		nx_addr    = '0;
		nx_pos     = '0;
		case (cmd.kind)
			K_PUSH_FRONT, K_PUSH_BACK, K_INSERT: begin
				if (full) begin
					imm        = 1'b1;
					imm_status = ST_FULL;
				end else begin
					if (cmd.kind == K_PUSH_FRONT) begin
						tgt_c = '0;
					end else if (cmd.kind == K_PUSH_BACK || p_w > c_w) begin
						tgt_c = cnt_q;
					end else begin
						tgt_c = CNT_W'(p_w);
					end
					nx_mode = M_UP;
					nx_tgt  = IDX_W'(tgt_c);
					nx_stop = IDX_W'(tgt_c);
					nx_addr = IDX_W'(c_m1);
					nx_pos  = to_pos5(WIDE_W'(tgt_c));
					// appending needs no shift
					go_put  = (tgt_c == cnt_q);
					go_walk = (tgt_c != cnt_q);
				end
			end
			K_POP_FRONT, K_POP_BACK, K_FRONT, K_BACK, K_REMOVE, K_FIND: begin
				if (empty) begin
					imm        = 1'b1;
					imm_status = ST_EMPTY;
					imm_val    = '1;
				end else if (cmd.kind == K_FIND) begin
					nx_mode = M_FIND;
					nx_addr = '0;
					nx_stop = IDX_W'(c_m1);
					nx_pos  = to_pos5(c_w);
					go_walk = 1'b1;
				end else if (cmd.kind == K_REMOVE && p_w >= c_w) begin
					imm        = 1'b1;
					imm_status = ST_IDX;
					imm_pos    = cmd.position_in;
				end else begin
					if (cmd.kind == K_POP_FRONT || cmd.kind == K_FRONT) begin
						p = '0;
					end else if (cmd.kind == K_POP_BACK || cmd.kind == K_BACK) begin
						p = IDX_W'(c_m1);
					end else begin
						p = IDX_W'(p_w);
					end
					if (cmd.kind == K_FRONT || cmd.kind == K_BACK) begin
						nx_mode = M_READ;
						nx_stop = p;
					end else begin
						nx_mode = M_DOWN;
						nx_stop = IDX_W'(c_m1);
					end
					nx_tgt  = p;
					nx_addr = p;
					nx_pos  = to_pos5(WIDE_W'(p));
					go_walk = 1'b1;
				end
			end
			default: begin
				imm = 1'b1;
			end
		endcase
	end

	assign match    = (state_q == S_WALK) && (mode_q == M_FIND) && rd_vld_s1 &&
	                  (rdata == val_q);
	assign drained  = (state_q == S_WALK) && !iss_q && !rd_vld_s1;
	assign walk_end = match || drained;
	assign issue    = (state_q == S_WALK) && iss_q && !match;

	// RAM traffic: read one entry ahead, shift it one place; put writes the new value
	always_comb begin
		ram       = '0;
		ram.re    = issue;
		ram.raddr = rd_addr_q;
		if (state_q == S_PUT) begin
			ram.we    = 1'b1;
			ram.waddr = tgt_q;
			ram.wdata = val_q;
		end else if (rd_vld_s1 && mode_q == M_UP) begin
			ram.we    = 1'b1;
			ram.waddr = rd_addr_s1 + 1'b1;
			ram.wdata = rdata;
		end else if (rd_vld_s1 && mode_q == M_DOWN && rd_addr_s1 != tgt_q) begin
			ram.we    = 1'b1;
			ram.waddr = rd_addr_s1 - 1'b1;
			ram.wdata = rdata;
		end
	end

	always_comb begin
		fin = '0;
		if (acc && imm) begin
			fin.valid  = 1'b1;
			fin.status = imm_status;
			fin.value  = imm_val;
			fin.pos    = imm_pos;
			fin.cnt    = cnt_q;
		end else if (state_q == S_PUT) begin
			fin.valid  = 1'b1;
			fin.status = ST_OK;
			fin.pos    = res_pos_q;
			fin.cnt    = cnt_q + 1'b1;
		end else if (walk_end && mode_q != M_UP) begin
			fin.valid  = 1'b1;
			fin.status = ST_OK;
			fin.value  = res_val_q;
			fin.pos    = match ? to_pos5(WIDE_W'(rd_addr_s1)) : res_pos_q;
			fin.cnt    = (mode_q == M_DOWN) ? cnt_q - 1'b1 : cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			iss_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			cnt_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			if (fin.valid) begin
				cnt_q <= fin.cnt;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						iss_q <= go_walk;
						if (go_walk) begin
							state_q <= S_WALK;
						end else if (go_put) begin
							state_q <= S_PUT;
						end
					end
				end
				S_WALK: begin
					if (issue && rd_addr_q == stop_q) begin
						iss_q <= 1'b0;
					end
					if (walk_end) begin
						iss_q   <= 1'b0;
						state_q <= (mode_q == M_UP) ? S_PUT : S_IDLE;
					end
				end
				S_PUT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr_q;
		if (acc) begin
			mode_q    <= nx_mode;
			tgt_q     <= nx_tgt;
			stop_q    <= nx_stop;
			rd_addr_q <= nx_addr;
			val_q     <= cmd.value_in;
			res_val_q <= '0;
			res_pos_q <= nx_pos;
		end else begin
			if (issue) begin
				rd_addr_q <= (mode_q == M_UP) ? rd_addr_q - 1'b1 : rd_addr_q + 1'b1;
			end
			if (rd_vld_s1 && (mode_q == M_READ ||
			    (mode_q == M_DOWN && rd_addr_s1 == tgt_q))) begin
				res_val_q <= rdata;
			end
		end
	end

endmodule

// ===== hdl/ordered_list_engine.sv =====
// Ordered list engine top level: sequencer, entry RAM and result word register.
// Rejected or no-op commands report in the cycle after start, an append from the put
//   state; a walk reports when its reads drain or a find hits, a shifting insert via put.
// Throughput: rejected and no-op commands free the input at once; any other holds busy
//   until its result word shows, at most one RAM read and one RAM write per cycle.
// Reset: arst_n clears the count and the sequencer; RAM contents are left as they are.
// The receiver cannot stall: each result word shows for one cycle with done high.
module ordered_list_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ole_pkg::in_word_t  cmd,
	output logic               done,
	output ole_pkg::out_word_t result
);
	import ole_pkg::*;

	fin_t              fin;
	ram_req_t          ram;
	logic [DATA_W-1:0] rdata;

	// command decode and RAM walk
	ole_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.fin    (fin),
		.ram    (ram),
		.rdata  (rdata)
	);

	// entries, index 0 is the front; only indexes below the count are ever read
	ole_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.re    (ram.re),
		.raddr (ram.raddr),
		.rdata (rdata)
	);

	// result word register; count reported in its low five bits
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			result.status       <= fin.status;
			result.value_out    <= fin.value;
			result.position_out <= fin.pos;
			result.count        <= to_pos5(WIDE_W'(fin.cnt));
		end
	end

	assign done = done_q;

	// a result word always leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while sequencer busy");

	// full rejection only when the list holds CAPACITY entries
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |->
			(result.count == to_pos5(WIDE_W'(CAPACITY))))
		else $error("full status with short list");

	// empty status reports an empty list and the all-ones word
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_EMPTY) |->
			(result.count == '0 && result.value_out == '1))
		else $error("empty status with bad word");

endmodule
